/* sv/akbd_pkg.sv */
// Shared types, register indexes and bit-swap functions for the byte decryptor.
`default_nettype none

package akbd_pkg;

   // register indexes on the configuration port
   localparam logic [2:0] CSR_SWAP_KEY_FIRST  = 3'd0;
   localparam logic [2:0] CSR_SWAP_KEY_SECOND = 3'd1;
   localparam logic [2:0] CSR_ADDRESS_KEY     = 3'd2;
   localparam logic [2:0] CSR_XOR_KEY_BYTE    = 3'd3;
   localparam logic [2:0] CSR_BASE_ADDRESS    = 3'd4;

   // data select is formed from the address flipped by this mask
   localparam logic [15:0] DATA_SELECT_MASK = 16'h1fc0;

   // key registers as seen by the pipeline
   typedef struct packed {
      logic [31:0] swap_key_first;
      logic [31:0] swap_key_second;
      logic [15:0] address_key;
      logic [7:0]  xor_key_byte;
      logic [15:0] base_address;
   } key_set_type;

   // item leaving the select stages
   typedef struct packed {
      logic        valid;
      logic [15:0] sel_op;
      logic [15:0] sel_dat;
      logic [7:0]  cipher;
   } sel_item_type;

   // pair j swapped when the select bit picked by nibble j is set
   function automatic logic [7:0] swap_a(input logic [7:0] v, input logic [15:0] key,
                                         input logic [7:0] sel);
      logic [7:0] r;
      r = v;
      for (int j = 0; j < 4; j++) begin
         if (sel[key[4*j +: 3]]) begin
            r[2*j]   = v[2*j+1];
            r[2*j+1] = v[2*j];
         end
      end
      return r;
   endfunction

   // pair j swapped when the select bit picked by nibble 3-j is set
   function automatic logic [7:0] swap_b(input logic [7:0] v, input logic [15:0] key,
                                         input logic [7:0] sel);
      logic [7:0] r;
      r = v;
      for (int j = 0; j < 4; j++) begin
         if (sel[key[4*(3-j) +: 3]]) begin
            r[2*j]   = v[2*j+1];
            r[2*j+1] = v[2*j];
         end
      end
      return r;
   endfunction

   function automatic logic [7:0] rotl1(input logic [7:0] v);
      return {v[6:0], v[7]};
   endfunction

endpackage

`default_nettype wire

/* sv/akbd_sel.sv */
// Select stages: address offset, then opcode and data select sums.
`default_nettype none

module akbd_sel import akbd_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         in_valid,
   input  wire logic [15:0]  in_address,
   input  wire logic [7:0]   in_cipher,
   input  wire key_set_type  keys,
   output sel_item_type      out_item
);

   logic        s1_valid_ff, s1_valid_in;
   logic [15:0] s1_full_ff, s1_full_in;
   logic [7:0]  s1_cipher_ff;
   sel_item_type s2_item_ff, s2_item_in;

   // stage 1: address plus base
   assign s1_valid_in = in_valid;
   assign s1_full_in  = in_address + keys.base_address;

   // stage 2: both selects, wrapping at 16 bits
   always_comb begin
      s2_item_in.valid   = s1_valid_ff;
      s2_item_in.sel_op  = s1_full_ff + keys.address_key;
      s2_item_in.sel_dat = (s1_full_ff ^ DATA_SELECT_MASK) + keys.address_key + 16'd1;
      s2_item_in.cipher  = s1_cipher_ff;
   end

   // valid bits reset, data registers free-running
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff       <= 1'b0;
         s2_item_ff.valid  <= 1'b0;
      end else begin
         s1_valid_ff       <= s1_valid_in;
         s2_item_ff.valid  <= s2_item_in.valid;
      end
      s1_full_ff          <= s1_full_in;
      s1_cipher_ff        <= in_cipher;
      s2_item_ff.sel_op   <= s2_item_in.sel_op;
      s2_item_ff.sel_dat  <= s2_item_in.sel_dat;
      s2_item_ff.cipher   <= s2_item_in.cipher;
   end

   assign out_item = s2_item_ff;

endmodule

`default_nettype wire

/* sv/akbd_dec.sv */
// Decode stages: low-select swap half, then high-select swap half, both decodes.
`default_nettype none

module akbd_dec import akbd_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire sel_item_type  in_item,
   input  wire key_set_type   keys,
   output logic               out_valid,
   output logic [7:0]         out_opcode,
   output logic [7:0]         out_operand
);

   logic       s3_valid_ff;
   logic [7:0] s3_op_ff, s3_op_in;
   logic [7:0] s3_dat_ff, s3_dat_in;
   logic [7:0] s3_hi_op_ff, s3_hi_dat_ff;
   logic       s4_valid_ff;
   logic [7:0] s4_op_ff, s4_op_in;
   logic [7:0] s4_dat_ff, s4_dat_in;

   // stage 3: swap A, rotate, swap B, xor, rotate (low select byte)
   always_comb begin
      s3_op_in  = rotl1(swap_b(rotl1(swap_a(in_item.cipher, keys.swap_key_first[15:0],
                                            in_item.sel_op[7:0])),
                               keys.swap_key_first[31:16], in_item.sel_op[7:0])
                        ^ keys.xor_key_byte);
      s3_dat_in = rotl1(swap_b(rotl1(swap_a(in_item.cipher, keys.swap_key_first[15:0],
                                            in_item.sel_dat[7:0])),
                               keys.swap_key_first[31:16], in_item.sel_dat[7:0])
                        ^ keys.xor_key_byte);
   end

   // stage 4: swap B, rotate, swap A (high select byte)
   always_comb begin
      s4_op_in  = swap_a(rotl1(swap_b(s3_op_ff, keys.swap_key_second[15:0], s3_hi_op_ff)),
                         keys.swap_key_second[31:16], s3_hi_op_ff);
      s4_dat_in = swap_a(rotl1(swap_b(s3_dat_ff, keys.swap_key_second[15:0], s3_hi_dat_ff)),
                         keys.swap_key_second[31:16], s3_hi_dat_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else begin
         s3_valid_ff <= in_item.valid;
         s4_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s3_op_ff     <= s3_op_in;
      s3_dat_ff    <= s3_dat_in;
      s3_hi_op_ff  <= in_item.sel_op[15:8];
      s3_hi_dat_ff <= in_item.sel_dat[15:8];
      s4_op_ff     <= s4_op_in;
      s4_dat_ff    <= s4_dat_in;
   end

   assign out_valid   = s4_valid_ff;
   assign out_opcode  = s4_op_ff;
   assign out_operand = s4_dat_ff;

endmodule

`default_nettype wire

/* sv/address_keyed_byte_decryptor_top.sv */
// Top level of the address-keyed byte decryptor: key registers and pipeline.
//
//   channel   ports                                   handshake
//   request   start, busy, req_address, req_cipher_byte   start & !busy
//   response  rsp_strobe, rsp_opcode_byte, rsp_operand_byte  rsp_strobe, one cycle
//   config    csr_write_enable, csr_index, csr_write_data    csr_write_enable
//
// One item per cycle sustained; an item's result is on the result ports once it has
// passed each register stage in turn: address add, select add, then the two swap
// halves.
// busy is always low: the pipeline never stalls, the receiver cannot hold it.
// Synchronous reset clears the valid bits and zeroes all key registers.
`default_nettype none

module address_keyed_byte_decryptor_top import akbd_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [15:0] req_address,
   input  wire logic [7:0]  req_cipher_byte,
   output logic             rsp_strobe,
   output logic [7:0]       rsp_opcode_byte,
   output logic [7:0]       rsp_operand_byte,
   input  wire logic        csr_write_enable,
   input  wire logic [2:0]  csr_index,
   input  wire logic [31:0] csr_write_data
);

   key_set_type  keys_ff;
   sel_item_type sel_item;
   logic         accept;

   assign busy   = 1'b0;
   assign accept = start & ~busy;

   // key registers
   always_ff @(posedge clock) begin
      if (reset) begin
         keys_ff <= '0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_SWAP_KEY_FIRST:  keys_ff.swap_key_first  <= csr_write_data;
            CSR_SWAP_KEY_SECOND: keys_ff.swap_key_second <= csr_write_data;
            CSR_ADDRESS_KEY:     keys_ff.address_key     <= csr_write_data[15:0];
            CSR_XOR_KEY_BYTE:    keys_ff.xor_key_byte    <= csr_write_data[7:0];
            CSR_BASE_ADDRESS:    keys_ff.base_address    <= csr_write_data[15:0];
            default: ;
         endcase
      end
   end

   akbd_sel u_sel (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (accept),
      .in_address (req_address),
      .in_cipher  (req_cipher_byte),
      .keys       (keys_ff),
      .out_item   (sel_item)
   );

   akbd_dec u_dec (
      .clock       (clock),
      .reset       (reset),
      .in_item     (sel_item),
      .keys        (keys_ff),
      .out_valid   (rsp_strobe),
      .out_opcode  (rsp_opcode_byte),
      .out_operand (rsp_operand_byte)
   );

endmodule

`default_nettype wire

/* sim/testbench.sv */
// Self-checking testbench for the address-keyed byte decryptor top level.
`timescale 1ns / 100ps

module testbench;
   import akbd_pkg::*;

   localparam int          LATENCY       = 4;
   localparam logic [15:0] DATA_FLIP     = 16'h1fc0;
   localparam logic [2:0]  CSR_TOP_INDEX = 3'd7;
   localparam int          PROBE_COUNT   = 16;
   localparam int          SEGMENTS      = 7;
   localparam int          SEGMENT_ITEMS = 100;

   typedef struct packed {
      logic [7:0] opcode;
      logic [7:0] operand;
   } decoded_pair_type;

   typedef struct packed {
      logic [15:0] address;
      logic [7:0]  cipher;
      logic        typed;
      logic [7:0]  opcode;
      logic [7:0]  operand;
   } probe_row_type;

   // fixed probes; typed results hold only with every key at zero
   localparam probe_row_type PROBE_ROWS [PROBE_COUNT] = '{
      '{16'h0000, 8'h00, 1'b1, 8'h00, 8'h00},
      '{16'hffff, 8'hff, 1'b1, 8'hff, 8'hff},
      '{16'h0000, 8'h01, 1'b1, 8'h08, 8'h80},
      '{16'h0000, 8'h80, 1'b1, 8'h04, 8'h40},
      '{16'hffff, 8'h00, 1'b1, 8'h00, 8'h00},
      '{16'h0000, 8'hff, 1'b1, 8'hff, 8'hff},
      '{16'hffff, 8'h5a, 1'b0, 8'h00, 8'h00},
      '{16'h0001, 8'ha5, 1'b0, 8'h00, 8'h00},
      '{16'h00ff, 8'h01, 1'b0, 8'h00, 8'h00},
      '{16'hff00, 8'h80, 1'b0, 8'h00, 8'h00},
      '{16'h8000, 8'h55, 1'b0, 8'h00, 8'h00},
      '{16'h1fc0, 8'haa, 1'b0, 8'h00, 8'h00},
      '{16'he03f, 8'h3c, 1'b0, 8'h00, 8'h00},   // data select wraps to zero
      '{16'h5555, 8'hc3, 1'b0, 8'h00, 8'h00},
      '{16'haaaa, 8'h0f, 1'b0, 8'h00, 8'h00},
      '{16'h7fff, 8'hf0, 1'b0, 8'h00, 8'h00}
   };

   logic        clock            = 1'b0;
   logic        reset            = 1'b1;
   logic        start            = 1'b0;
   logic        busy;
   logic [15:0] req_address      = '0;
   logic [7:0]  req_cipher_byte  = '0;
   logic        rsp_strobe;
   logic [7:0]  rsp_opcode_byte;
   logic [7:0]  rsp_operand_byte;
   logic        csr_write_enable = 1'b0;
   logic [2:0]  csr_index        = '0;
   logic [31:0] csr_write_data   = '0;

   // local copy of the key registers
   logic [31:0] key_swap_first   = '0;
   logic [31:0] key_swap_second  = '0;
   logic [15:0] key_address      = '0;
   logic [7:0]  key_xor          = '0;
   logic [15:0] key_base         = '0;

   decoded_pair_type pending_bytes[$];
   int               failures = 0;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   address_keyed_byte_decryptor_top dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_address      (req_address),
      .req_cipher_byte  (req_cipher_byte),
      .rsp_strobe       (rsp_strobe),
      .rsp_opcode_byte  (rsp_opcode_byte),
      .rsp_operand_byte (rsp_operand_byte),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   // four pair swaps; reversed stages take their selector nibbles high to low
   function automatic logic [7:0] pair_swaps(input logic [7:0] v, input logic [15:0] key,
                                             input logic [7:0] sel, input logic reversed);
      logic [7:0] res;
      logic [2:0] pick;
      int         nib;
      res = v;
      for (int p = 0; p < 4; p++) begin
         nib  = reversed ? 3 - p : p;
         pick = key[4*nib +: 3];
         if (sel[pick]) res[2*p +: 2] = {res[2*p], res[2*p+1]};
      end
      return res;
   endfunction

   function automatic logic [7:0] rot_left(input logic [7:0] v);
      return {v[6:0], v[7]};
   endfunction

   function automatic logic [7:0] decrypt_byte(input logic [7:0] cipher, input logic [15:0] sel);
      logic [7:0] v;
      v = pair_swaps(cipher, key_swap_first[15:0], sel[7:0], 1'b0);
      v = rot_left(v);
      v = pair_swaps(v, key_swap_first[31:16], sel[7:0], 1'b1);
      v = rot_left(v ^ key_xor);
      v = pair_swaps(v, key_swap_second[15:0], sel[15:8], 1'b1);
      v = rot_left(v);
      v = pair_swaps(v, key_swap_second[31:16], sel[15:8], 1'b0);
      return v;
   endfunction

   // both decodes of one item; selects wrap at 16 bits
   function automatic decoded_pair_type decrypt_pair(input logic [15:0] address,
                                                     input logic [7:0] cipher);
      logic [15:0]      full;
      decoded_pair_type res;
      full        = address + key_base;
      res.opcode  = decrypt_byte(cipher, full + key_address);
      res.operand = decrypt_byte(cipher, (full ^ DATA_FLIP) + key_address + 16'd1);
      return res;
   endfunction

   function automatic logic [31:0] random_key();
      case ($urandom_range(0, 5))
         0: return '0;
         1: return '1;
         default: return $urandom;
      endcase
   endfunction

   task automatic report_mismatch(input string line);
      $display("%0t: %s", $realtime, line);
      failures++;
   endtask

   // caller lowers the write enable after the last write of a batch
   task automatic write_key(input logic [2:0] index, input logic [31:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= index;
      csr_write_data   <= data;
      @(posedge clock);
      case (index)
         CSR_SWAP_KEY_FIRST:  key_swap_first  = data;
         CSR_SWAP_KEY_SECOND: key_swap_second = data;
         CSR_ADDRESS_KEY:     key_address     = data[15:0];
         CSR_XOR_KEY_BYTE:    key_xor         = data[7:0];
         CSR_BASE_ADDRESS:    key_base        = data[15:0];
         default: ;
      endcase
   endtask

   task automatic send_item(input logic [15:0] address, input logic [7:0] cipher,
                            input logic typed, input logic [7:0] opcode,
                            input logic [7:0] operand);
      decoded_pair_type want;
      start           <= 1'b1;
      req_address     <= address;
      req_cipher_byte <= cipher;
      do @(posedge clock); while (busy !== 1'b0);
      if (typed) begin
         want.opcode  = opcode;
         want.operand = operand;
      end else begin
         want = decrypt_pair(address, cipher);
      end
      pending_bytes.push_back(want);
   endtask

   // each cycle idles with the given chance, so that share of cycles is idle
   task automatic idle_gap(input int percent);
      int gap;
      gap = 0;
      while ($urandom_range(0, 99) < percent) gap++;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // hold off until every pending item has come back
   task automatic drain();
      start <= 1'b0;
      while (pending_bytes.size() != 0) @(posedge clock);
      repeat (LATENCY + 2) @(posedge clock);
   endtask

   // result checker
   always @(posedge clock) begin
      decoded_pair_type want;
      if (!reset && rsp_strobe === 1'b1) begin
         if (pending_bytes.size() == 0) begin
            report_mismatch($sformatf("unexpected item %02h/%02h",
                                      rsp_opcode_byte, rsp_operand_byte));
         end else begin
            want = pending_bytes.pop_front();
            if (rsp_opcode_byte !== want.opcode)
               report_mismatch($sformatf("opcode_byte %02h, expected %02h",
                                         rsp_opcode_byte, want.opcode));
            if (rsp_operand_byte !== want.operand)
               report_mismatch($sformatf("operand_byte %02h, expected %02h",
                                         rsp_operand_byte, want.operand));
         end
      end
   end

   initial begin
      int          idle_pct;
      logic [15:0] fetch_address;
      logic [7:0]  fetch_cipher;

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // fixed probes with keys at their reset values
      for (int i = 0; i < PROBE_COUNT; i++) begin
         send_item(PROBE_ROWS[i].address, PROBE_ROWS[i].cipher, PROBE_ROWS[i].typed,
                   PROBE_ROWS[i].opcode, PROBE_ROWS[i].operand);
      end
      drain();

      fetch_address = 16'($urandom_range(0, 65535));
      for (int seg = 0; seg < SEGMENTS; seg++) begin
         // new key set: all ones, then ignored-bit and over-wide values, then random
         if (seg == 0) begin
            write_key(CSR_SWAP_KEY_FIRST, '1);
            write_key(CSR_SWAP_KEY_SECOND, '1);
            write_key(CSR_ADDRESS_KEY, '1);
            write_key(CSR_XOR_KEY_BYTE, '1);
            write_key(CSR_BASE_ADDRESS, '1);
         end else if (seg == 1) begin
            write_key(CSR_SWAP_KEY_FIRST, 32'h8888_8888);
            write_key(CSR_SWAP_KEY_SECOND, 32'h8888_8888);
            write_key(CSR_ADDRESS_KEY, 32'hffff_0000);
            write_key(CSR_XOR_KEY_BYTE, 32'hffff_ff00);
            write_key(CSR_BASE_ADDRESS, 32'h0001_ffff);
         end else begin
            write_key(CSR_SWAP_KEY_FIRST, random_key());
            write_key(CSR_SWAP_KEY_SECOND, random_key());
            write_key(CSR_ADDRESS_KEY, random_key());
            write_key(CSR_XOR_KEY_BYTE, random_key());
            write_key(CSR_BASE_ADDRESS, random_key());
         end
         // writes to unused indexes must leave the keys alone
         for (int k = CSR_BASE_ADDRESS + 1; k <= CSR_TOP_INDEX; k++)
            write_key(3'(k), $urandom);
         csr_write_enable <= 1'b0;

         idle_pct = (seg < 3) ? 28 : (seg < 5) ? 63 : 0;
         for (int n = 0; n < SEGMENT_ITEMS; n++) begin
            if (seg == 1 && n == SEGMENT_ITEMS / 2) drain();
            // mostly sequential fetches, with jumps and runs across the wrap
            case ($urandom_range(0, 9))
               0: fetch_address = 16'($urandom_range(0, 65535));
               1: fetch_address = 16'hffff - 16'($urandom_range(0, 3));
               2: fetch_address = 16'($urandom_range(0, 3));
               default: fetch_address = fetch_address + 16'd1;
            endcase
            fetch_cipher = 8'($urandom_range(0, 255));
            idle_gap(idle_pct);
            send_item(fetch_address, fetch_cipher, 1'b0, 8'h00, 8'h00);
         end
         drain();
      end

      if (failures == 0 && pending_bytes.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   // run limit
   initial begin
      #2_000_000;
      $display("FAILED: results differ");
      $finish;
   end

endmodule
